// File: hdl/sq_flow_control_tracker_macros.svh
// Assertion macros for the submission queue flow-control tracker.
// Used by the top level only; needs i_clk and i_rst_n in the including scope.
`ifndef SQ_FLOW_CONTROL_TRACKER_MACROS_SVH
`define SQ_FLOW_CONTROL_TRACKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SQFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SQFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sqfc_pkg.sv
// Shared types, codes and helpers for the submission queue flow-control tracker.
// No dependencies; every other file but the assertion macro header refers to this package by scoped names.
package sqfc_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_CONNECT  = 2'd0;
    localparam logic [1:0] OP_SUBMIT   = 2'd1;
    localparam logic [1:0] OP_RESPONSE = 2'd2;

    // Result codes.
    localparam logic [3:0] RC_OK          = 4'd0;
    localparam logic [3:0] RC_FULL        = 4'd1;
    localparam logic [3:0] RC_EMPTY       = 4'd2;
    localparam logic [3:0] RC_LINK_ERR    = 4'd3;
    localparam logic [3:0] RC_BAD_SETUP   = 4'd4;
    localparam logic [3:0] RC_REJECTED    = 4'd5;
    localparam logic [3:0] RC_CID_MISS    = 4'd6;
    localparam logic [3:0] RC_NO_HEAD     = 4'd7;
    localparam logic [3:0] RC_FC_REFUSED  = 4'd8;
    localparam logic [3:0] RC_AUTH_NEEDED = 4'd9;

    // Configuration register indexes.
    localparam logic [2:0] REG_QUEUE_ENTRIES = 3'd0;
    localparam logic [2:0] REG_ADMIN_ROLE    = 3'd1;
    localparam logic [2:0] REG_QUEUE_NUMBER  = 3'd2;
    localparam logic [2:0] REG_WANT_FC       = 3'd3;
    localparam logic [2:0] REG_KEEP_ALIVE    = 3'd4;

    // Command ID that is never handed out, and the head value that turns off flow control.
    localparam logic [15:0] CID_SKIP   = 16'hFFFF;
    localparam logic [15:0] NO_FC_HEAD = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  op;
        logic        link_ok;
        logic [15:0] rsp_status;
        logic        cid_matches;
        logic        head_valid;
        logic [15:0] head_value;
        logic        auth_request;
        logic [15:0] rsp_controller;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  result_code;
        logic [15:0] issued_cid;
        logic [15:0] head_now;
        logic [15:0] tail_now;
        logic        flow_control_on;
        logic        queue_idle;
        logic [15:0] controller_id;
    } t_out_word;

    // Configuration as the datapath sees it.
    typedef struct packed {
        logic [16:0] queue_entries;
        logic        want_fc;
        logic        setup_ok;
    } t_cfg;

    // Status of the iterative remainder unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_status;

    // Fast pointer advance: covers every case except p + 1 above a nonzero queue size.
    typedef struct packed {
        logic        slow;
        logic [15:0] val;
    } t_adv;

    function automatic t_adv adv_fast(logic [15:0] p, logic [16:0] q);
        logic [16:0] p1;
        t_adv        r;
        p1     = {1'b0, p} + 17'd1;
        r.slow = 1'b0;
        r.val  = p1[15:0];
        if (q == 17'd0) begin
            r.val = p1[15:0];
        end else if (p1 < q) begin
            r.val = p1[15:0];
        end else if (p1 == q) begin
            r.val = 16'd0;
        end else begin
            r.slow = 1'b1;
        end
        return r;
    endfunction

endpackage

// File: hdl/sqfc_mod_unit.sv
// Iterative remainder unit, one quotient bit per cycle (restoring division).
// Depends on sqfc_pkg for the status struct.
module sqfc_mod_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_clear,
    input  logic [16:0]          i_dividend,
    input  logic [16:0]          i_divisor,
    output sqfc_pkg::t_mod_status o_status,
    output logic [15:0]          o_result
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} t_state;

    t_state      r_state;
    logic [4:0]  r_count;
    logic [16:0] r_div;
    logic [16:0] r_rem;

    logic [17:0] trial;
    logic [16:0] n_rem;

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    always_comb begin
        trial = {r_rem, r_div[16]};
        if (trial >= {1'b0, i_divisor}) begin
            n_rem = 17'(trial - {1'b0, i_divisor});
        end else begin
            n_rem = trial[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= 5'd0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_RUN;
                        r_count <= 5'd16;
                        r_div   <= i_dividend;
                        r_rem   <= 17'd0;
                    end
                end
                ST_RUN: begin
                    r_rem <= n_rem;
                    r_div <= {r_div[15:0], 1'b0};
                    if (r_count == 5'd0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_count <= r_count - 5'd1;
                    end
                end
                ST_DONE: begin
                    if (i_clear) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_status.busy = (r_state == ST_RUN);
    assign o_status.done = (r_state == ST_DONE);
    assign o_result      = r_rem[15:0];

endmodule

// File: hdl/sqfc_cfg.sv
// Configuration registers and the connect setup check.
// Depends on sqfc_pkg for register indexes and the configuration struct.
module sqfc_cfg #(
    parameter int MIN_ADMIN_ENTRIES = 2,
    parameter int MAX_ADMIN_ENTRIES = 4096,
    parameter int MIN_IO_ENTRIES    = 2,
    parameter int MAX_IO_ENTRIES    = 65536
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data,
    output sqfc_pkg::t_cfg o_cfg
);

    logic [16:0] r_queue_entries;
    logic        r_admin_role;
    logic [15:0] r_queue_number;
    logic        r_want_fc;
    logic        r_ka_nonzero;

    logic is_admin;
    logic setup_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_entries <= 17'd32;
            r_admin_role    <= 1'b1;
            r_queue_number  <= 16'd0;
            r_want_fc       <= 1'b1;
            r_ka_nonzero    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sqfc_pkg::REG_QUEUE_ENTRIES: r_queue_entries <= i_cfg_data[16:0];
                sqfc_pkg::REG_ADMIN_ROLE:    r_admin_role    <= i_cfg_data[0];
                sqfc_pkg::REG_QUEUE_NUMBER:  r_queue_number  <= i_cfg_data[15:0];
                sqfc_pkg::REG_WANT_FC:       r_want_fc       <= i_cfg_data[0];
                sqfc_pkg::REG_KEEP_ALIVE:    r_ka_nonzero    <= (i_cfg_data != 32'd0);
                default: ;
            endcase
        end
    end

    // Only whether the keep-alive timeout is nonzero matters to the setup check.
    always_comb begin
        is_admin = (r_queue_number == 16'd0);
        setup_ok = 1'b1;
        if (r_admin_role != is_admin) begin
            setup_ok = 1'b0;
        end else if (is_admin) begin
            if (r_queue_entries < 17'(MIN_ADMIN_ENTRIES) ||
                r_queue_entries > 17'(MAX_ADMIN_ENTRIES)) begin
                setup_ok = 1'b0;
            end
        end else begin
            if (r_queue_entries < 17'(MIN_IO_ENTRIES) ||
                r_queue_entries > 17'(MAX_IO_ENTRIES) || r_ka_nonzero) begin
                setup_ok = 1'b0;
            end
        end
    end

    assign o_cfg.queue_entries = r_queue_entries;
    assign o_cfg.want_fc       = r_want_fc;
    assign o_cfg.setup_ok      = setup_ok;

endmodule

// File: hdl/sq_flow_control_tracker.sv
// A pointer above the queue size makes a word wait in the input register for a true
// remainder from the one-bit-per-cycle remainder unit before its result word lands in
// the output register. Throughput: one word per cycle; while the remainder unit runs or
// a result waits in a stalled output register, the input register holds its word and
// the input stalls. Reset (synchronous, active low) clears pointers, command ID,
// flow-control mode and controller ID, and loads the register defaults 32, 1, 0, 1, 0.
`include "sq_flow_control_tracker_macros.svh"

module sq_flow_control_tracker #(
    parameter int MIN_ADMIN_ENTRIES = 2,
    parameter int MAX_ADMIN_ENTRIES = 4096,
    parameter int MIN_IO_ENTRIES    = 2,
    parameter int MAX_IO_ENTRIES    = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input channel.
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sqfc_pkg::t_in_word  i_in_word,
    // Output channel.
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sqfc_pkg::t_out_word o_out_word,
    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    // The design is a two-register pipe: an input register holds the word while the
    // queue state is updated from it, and the result word lands in an output register.
    // The input register can take one more word while a finished result waits to be taken.

    sqfc_pkg::t_cfg        cfg;
    sqfc_pkg::t_mod_status mod_st;
    logic [15:0]           mod_result;

    // Input register.
    logic                r_in_valid;
    sqfc_pkg::t_in_word  r_in;

    // Queue state.
    logic [15:0] r_head;
    logic [15:0] r_tail;
    logic [15:0] r_next_cid;
    logic        r_fc;
    logic [15:0] r_ctrl_id;

    // Output register.
    logic                r_out_valid;
    sqfc_pkg::t_out_word r_out;

    // Next values.
    logic [15:0]         n_head;
    logic [15:0]         n_tail;
    logic [15:0]         n_next_cid;
    logic                n_fc;
    logic [15:0]         n_ctrl_id;
    logic [3:0]          n_code;
    logic [15:0]         n_cid;
    sqfc_pkg::t_out_word n_out;

    sqfc_pkg::t_adv tail_adv;
    sqfc_pkg::t_adv head_adv;
    logic [15:0]    next_tail;
    logic [15:0]    next_head;
    logic           need_slow;
    logic           adv_ok;
    logic           fire;
    logic [16:0]    mod_dividend;
    logic           idle_agrees;

    sqfc_cfg #(
        .MIN_ADMIN_ENTRIES(MIN_ADMIN_ENTRIES),
        .MAX_ADMIN_ENTRIES(MAX_ADMIN_ENTRIES),
        .MIN_IO_ENTRIES   (MIN_IO_ENTRIES),
        .MAX_IO_ENTRIES   (MAX_IO_ENTRIES)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Pointer advance. The common cases (below the size, at the size, or a zero size
    // that wraps in 16 bits) are resolved at once. A pointer above a nonzero size can
    // only come from a controller-reported head or a size change, and then the
    // remainder unit works out (p + 1) mod size while the word waits.
    assign tail_adv = sqfc_pkg::adv_fast(r_tail, cfg.queue_entries);
    assign head_adv = sqfc_pkg::adv_fast(r_head, cfg.queue_entries);

    assign need_slow = r_in_valid &&
        ((r_in.op == sqfc_pkg::OP_SUBMIT && tail_adv.slow) ||
         (r_in.op == sqfc_pkg::OP_RESPONSE && !r_fc && (r_head != r_tail) &&
          r_in.link_ok && head_adv.slow));

    assign mod_dividend = (r_in.op == sqfc_pkg::OP_SUBMIT) ? ({1'b0, r_tail} + 17'd1)
                                                           : ({1'b0, r_head} + 17'd1);

    sqfc_mod_unit u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (need_slow && !mod_st.busy && !mod_st.done),
        .i_clear   (fire),
        .i_dividend(mod_dividend),
        .i_divisor (cfg.queue_entries),
        .o_status  (mod_st),
        .o_result  (mod_result)
    );

    assign next_tail = tail_adv.slow ? mod_result : tail_adv.val;
    assign next_head = head_adv.slow ? mod_result : head_adv.val;

    // The word in the input register completes when its advance is known and the
    // output register is free or being emptied in this cycle.
    assign adv_ok     = !need_slow || mod_st.done;
    assign fire       = r_in_valid && adv_ok && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;

    // Per-word processing. Connect checks run in a fixed order and the first one that
    // fails names the result; a failed connect leaves the state alone.
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_next_cid = r_next_cid;
        n_fc       = r_fc;
        n_ctrl_id  = r_ctrl_id;
        n_cid      = 16'd0;
        n_code     = sqfc_pkg::RC_BAD_SETUP;
        unique case (r_in.op)
            sqfc_pkg::OP_CONNECT: begin
                priority if (!cfg.setup_ok) begin
                    n_code = sqfc_pkg::RC_BAD_SETUP;
                end else if (!r_in.link_ok) begin
                    n_code = sqfc_pkg::RC_LINK_ERR;
                end else if (r_in.rsp_status != 16'd0) begin
                    n_code = sqfc_pkg::RC_REJECTED;
                end else if (!r_in.cid_matches) begin
                    n_code = sqfc_pkg::RC_CID_MISS;
                end else if (!r_in.head_valid) begin
                    n_code = sqfc_pkg::RC_NO_HEAD;
                end else if (r_in.head_value == sqfc_pkg::NO_FC_HEAD && cfg.want_fc) begin
                    n_code = sqfc_pkg::RC_FC_REFUSED;
                end else if (r_in.auth_request) begin
                    n_code = sqfc_pkg::RC_AUTH_NEEDED;
                end else begin
                    n_code = sqfc_pkg::RC_OK;
                    if (r_in.head_value == sqfc_pkg::NO_FC_HEAD) begin
                        n_fc   = 1'b0;
                        n_head = 16'd0;
                        n_tail = 16'd0;
                    end else begin
                        n_fc   = 1'b1;
                        n_head = r_in.head_value;
                        n_tail = r_in.head_value;
                    end
                    n_next_cid = 16'd0;
                    n_ctrl_id  = r_in.rsp_controller;
                end
            end
            sqfc_pkg::OP_SUBMIT: begin
                if (next_tail == r_head) begin
                    n_code = sqfc_pkg::RC_FULL;
                end else begin
                    // The command ID is used up even when the transmit fails.
                    n_cid      = r_next_cid;
                    n_next_cid = 16'(r_next_cid + 16'd1);
                    if (n_next_cid == sqfc_pkg::CID_SKIP) begin
                        n_next_cid = 16'd0;
                    end
                    if (!r_in.link_ok) begin
                        n_code = sqfc_pkg::RC_LINK_ERR;
                    end else begin
                        n_code = sqfc_pkg::RC_OK;
                        n_tail = next_tail;
                    end
                end
            end
            sqfc_pkg::OP_RESPONSE: begin
                priority if (r_head == r_tail) begin
                    n_code = sqfc_pkg::RC_EMPTY;
                end else if (!r_in.link_ok) begin
                    n_code = sqfc_pkg::RC_LINK_ERR;
                end else begin
                    n_code = sqfc_pkg::RC_OK;
                    if (r_fc) begin
                        // Under flow control the controller reports the head; a
                        // response without one keeps the old head.
                        if (r_in.head_valid) begin
                            n_head = r_in.head_value;
                        end
                    end else begin
                        n_head = next_head;
                    end
                end
            end
            default: begin
                n_code = sqfc_pkg::RC_BAD_SETUP;
            end
        endcase

        n_out.result_code     = n_code;
        n_out.issued_cid      = n_cid;
        n_out.head_now        = n_head;
        n_out.tail_now        = n_tail;
        n_out.flow_control_on = n_fc;
        n_out.queue_idle      = (n_head == n_tail);
        n_out.controller_id   = n_ctrl_id;
    end

    // Input register: loaded whenever the stage is free or completing this cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
            r_in       <= i_in_word;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // Queue state, updated once per completed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= 16'd0;
            r_tail     <= 16'd0;
            r_next_cid <= 16'd0;
            r_fc       <= 1'b0;
            r_ctrl_id  <= 16'd0;
        end else if (fire) begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_next_cid <= n_next_cid;
            r_fc       <= n_fc;
            r_ctrl_id  <= n_ctrl_id;
        end
    end

    // Output register: holds a result word until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
            r_out       <= n_out;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign idle_agrees = (r_out.queue_idle == (r_out.head_now == r_out.tail_now));

    // A completed word always shows up in the output register in the next cycle.
    `SQFC_ASSERT_NEXT(a_fire_to_out, fire, r_out_valid && (r_out.head_now == r_head), "lost word")
    // The reserved command ID is never handed out.
    `SQFC_ASSERT_NOW(a_cid_skip, r_out_valid, r_out.issued_cid != sqfc_pkg::CID_SKIP, "bad cid")
    // The remainder unit only runs for a word that is waiting in the input register.
    `SQFC_ASSERT_NOW(a_mod_owner, mod_st.busy || mod_st.done, r_in_valid, "stray remainder")
    // The idle flag agrees with the reported pointers.
    `SQFC_ASSERT_NOW(a_idle_flag, r_out_valid, idle_agrees, "queue idle flag inconsistent")

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for sq_flow_control_tracker. It sends connect, submit, response and
// unused-op words with random idling on both channels and checks each status word against
// a predictor. Depends on sqfc_pkg and the tracker RTL only.
module tb_top;

    // The input word's op field has one encoding that the block treats as a setup fault.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Queue size bounds as the block is built with its default parameters.
    localparam int ADMIN_MIN_ENTRIES = 2;
    localparam int ADMIN_MAX_ENTRIES = 4096;
    localparam int IO_MIN_ENTRIES    = 2;
    localparam int IO_MAX_ENTRIES    = 65536;

    // The cycle limit covers the slowest legal run: about 1250 words, each with a full
    // sender gap, a full receiver stall and a remainder pass, plus the drains around every
    // register load.
    localparam int CYCLE_LIMIT   = 400000;
    // A word passes through the input and output registers and may wait for a true
    // remainder in between; the settle wait covers any word still inside the block.
    localparam int SETTLE_CYCLES = 40;
    localparam int MSG_CAP       = 40;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    sqfc_pkg::t_in_word  in_word   = '0;
    logic                out_stall = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [2:0]          cfg_index = sqfc_pkg::REG_QUEUE_ENTRIES;
    logic [31:0]         cfg_data  = '0;
    logic                in_stall;
    logic                out_valid;
    sqfc_pkg::t_out_word out_word;

    // Predictor copy of the configuration registers, loaded with their reset values.
    logic [16:0] cfg_entries    = 17'd32;
    logic        cfg_admin      = 1'b1;
    logic [15:0] cfg_qid        = 16'd0;
    logic        cfg_want_fc    = 1'b1;
    logic [31:0] cfg_keep_alive = 32'd0;

    // Predictor copy of the queue accounting state; all of it clears at reset.
    logic [15:0] host_head = 16'd0;
    logic [15:0] host_tail = 16'd0;
    logic [15:0] host_cid  = 16'd0;
    logic        host_fc   = 1'b0;
    logic [15:0] host_ctrl = 16'd0;

    // Status words that the block still owes, oldest first.
    sqfc_pkg::t_out_word pending_status[$];

    int unsigned err_count   = 0;
    int unsigned cycle_count = 0;
    bit          tx_idle_on  = 1'b0;
    bit          rx_idle_on  = 1'b0;

    sq_flow_control_tracker dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A pointer moves to the next slot modulo the queue size. A size of zero, or one above
    // 65536, leaves only the 16-bit wrap.
    function automatic logic [15:0] step_ptr(logic [15:0] p);
        logic [31:0] n;
        n = 32'(p) + 32'd1;
        if (cfg_entries != 17'd0) begin
            n = n % 32'(cfg_entries);
        end
        return n[15:0];
    endfunction

    // Applies one accepted word to the predictor state and returns the status word that
    // the block must produce for it.
    function automatic sqfc_pkg::t_out_word account_word(sqfc_pkg::t_in_word w);
        sqfc_pkg::t_out_word r;
        logic [15:0]         nt;
        logic                setup_bad;
        r = '0;
        case (w.op)
            sqfc_pkg::OP_CONNECT: begin
                // Setup faults come first, then the response fields in a fixed order.
                if (cfg_qid == 16'd0) begin
                    setup_bad = !cfg_admin || cfg_entries < ADMIN_MIN_ENTRIES ||
                                cfg_entries > ADMIN_MAX_ENTRIES;
                end else begin
                    setup_bad = cfg_admin || cfg_entries < IO_MIN_ENTRIES ||
                                cfg_entries > IO_MAX_ENTRIES || cfg_keep_alive != 32'd0;
                end
                if (setup_bad) begin
                    r.result_code = sqfc_pkg::RC_BAD_SETUP;
                end else if (!w.link_ok) begin
                    r.result_code = sqfc_pkg::RC_LINK_ERR;
                end else if (w.rsp_status != 16'd0) begin
                    r.result_code = sqfc_pkg::RC_REJECTED;
                end else if (!w.cid_matches) begin
                    r.result_code = sqfc_pkg::RC_CID_MISS;
                end else if (!w.head_valid) begin
                    r.result_code = sqfc_pkg::RC_NO_HEAD;
                end else if (w.head_value == sqfc_pkg::NO_FC_HEAD && cfg_want_fc) begin
                    r.result_code = sqfc_pkg::RC_FC_REFUSED;
                end else if (w.auth_request) begin
                    r.result_code = sqfc_pkg::RC_AUTH_NEEDED;
                end else begin
                    // The reserved head value means the controller runs without flow control.
                    r.result_code = sqfc_pkg::RC_OK;
                    host_fc   = (w.head_value != sqfc_pkg::NO_FC_HEAD);
                    host_head = host_fc ? w.head_value : 16'd0;
                    host_tail = host_head;
                    host_cid  = 16'd0;
                    host_ctrl = w.rsp_controller;
                end
            end
            sqfc_pkg::OP_SUBMIT: begin
                nt = step_ptr(host_tail);
                if (nt == host_head) begin
                    r.result_code = sqfc_pkg::RC_FULL;
                end else begin
                    // The ID is spent even when the transmit fails.
                    r.issued_cid = host_cid;
                    host_cid = host_cid + 16'd1;
                    if (host_cid == sqfc_pkg::CID_SKIP) begin
                        host_cid = 16'd0;
                    end
                    if (!w.link_ok) begin
                        r.result_code = sqfc_pkg::RC_LINK_ERR;
                    end else begin
                        r.result_code = sqfc_pkg::RC_OK;
                        host_tail = nt;
                    end
                end
            end
            sqfc_pkg::OP_RESPONSE: begin
                if (host_head == host_tail) begin
                    r.result_code = sqfc_pkg::RC_EMPTY;
                end else if (!w.link_ok) begin
                    r.result_code = sqfc_pkg::RC_LINK_ERR;
                end else begin
                    r.result_code = sqfc_pkg::RC_OK;
                    if (!host_fc) begin
                        host_head = step_ptr(host_head);
                    end else if (w.head_valid) begin
                        host_head = w.head_value;
                    end
                end
            end
            default: begin
                r.result_code = sqfc_pkg::RC_BAD_SETUP;
            end
        endcase
        r.head_now        = host_head;
        r.tail_now        = host_tail;
        r.flow_control_on = host_fc;
        r.queue_idle      = (host_head == host_tail);
        r.controller_id   = host_ctrl;
        return r;
    endfunction

    function automatic sqfc_pkg::t_in_word pack_word(logic [1:0] op, logic link,
                                                     logic [15:0] status, logic cid_ok,
                                                     logic hv, logic [15:0] hval,
                                                     logic auth, logic [15:0] ctrl);
        sqfc_pkg::t_in_word w;
        w.op             = op;
        w.link_ok        = link;
        w.rsp_status     = status;
        w.cid_matches    = cid_ok;
        w.head_valid     = hv;
        w.head_value     = hval;
        w.auth_request   = auth;
        w.rsp_controller = ctrl;
        return w;
    endfunction

    function automatic sqfc_pkg::t_in_word connect_ok(logic [15:0] hval, logic [15:0] ctrl);
        return pack_word(sqfc_pkg::OP_CONNECT, 1'b1, 16'd0, 1'b1, 1'b1, hval, 1'b0, ctrl);
    endfunction

    // Head values are mostly legal slots of the current queue, with some outliers that
    // sit above the queue size or carry the reserved value.
    function automatic logic [15:0] pick_ptr();
        logic [15:0] span;
        span = (cfg_entries == 17'd0 || cfg_entries > 17'd65536) ?
               16'hFFFF : 16'(cfg_entries - 17'd1);
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return host_tail;
            2: return sqfc_pkg::NO_FC_HEAD;
            3, 4: return step_ptr(host_head);
            default: return 16'($urandom_range(0, span));
        endcase
    endfunction

    // Most words are submits and responses that walk the queue; connects that succeed
    // restart it, and a small share is malformed connects and the unused op.
    function automatic sqfc_pkg::t_in_word random_word();
        sqfc_pkg::t_in_word w;
        int unsigned        pick;
        w = pack_word(sqfc_pkg::OP_SUBMIT, $urandom_range(0, 9) != 0,
                      ($urandom_range(0, 1) != 0) ? 16'd0 : 16'($urandom),
                      $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0, pick_ptr(),
                      $urandom_range(0, 7) == 0, 16'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            w.op = OP_UNUSED;
        end else if (pick < 10) begin
            w.op = sqfc_pkg::OP_CONNECT;
        end else if (pick < 14) begin
            w = connect_ok((cfg_want_fc || $urandom_range(0, 1) != 0) ?
                           16'($urandom_range(0, 65534)) % 16'(cfg_entries | 17'd1) :
                           sqfc_pkg::NO_FC_HEAD, 16'($urandom));
            if ($urandom_range(0, 3) == 0) begin
                w.head_value = pick_ptr();
            end
        end else if (pick < 57) begin
            w.op = sqfc_pkg::OP_SUBMIT;
        end else begin
            w.op = sqfc_pkg::OP_RESPONSE;
        end
        return w;
    endfunction

    // Offers one word, holds it until the block takes it, and records what it owes.
    // Valid stays high afterwards so that the next word can follow without a bubble.
    task automatic send_word(input sqfc_pkg::t_in_word w);
        int unsigned gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
        end
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        pending_status.push_back(account_word(w));
    endtask

    // Stops sending and waits for every owed status word, then lets any word still
    // inside the block drain out.
    task automatic drain_queue();
        in_valid <= 1'b0;
        while (pending_status.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves the write enable high so that back-to-back writes follow without a gap.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Writes all five registers while the block is idle. The spare upper bits of the
    // narrow registers carry noise, which the block must ignore.
    task automatic load_setup(input logic [16:0] entries, input logic admin,
                              input logic [15:0] qid, input logic want_fc,
                              input logic [31:0] ka);
        drain_queue();
        write_reg(sqfc_pkg::REG_QUEUE_ENTRIES, {15'($urandom), entries});
        write_reg(sqfc_pkg::REG_ADMIN_ROLE, {31'($urandom), admin});
        write_reg(sqfc_pkg::REG_QUEUE_NUMBER, {16'($urandom), qid});
        write_reg(sqfc_pkg::REG_WANT_FC, {31'($urandom), want_fc});
        write_reg(sqfc_pkg::REG_KEEP_ALIVE, ka);
        cfg_we         <= 1'b0;
        cfg_entries    = entries;
        cfg_admin      = admin;
        cfg_qid        = qid;
        cfg_want_fc    = want_fc;
        cfg_keep_alive = ka;
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            err_count++;
            if (err_count <= MSG_CAP) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        end
    endtask

    // Every status word the receiver takes is matched against the oldest one owed.
    always @(posedge clk) begin
        sqfc_pkg::t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_status.size() == 0) begin
                err_count++;
                if (err_count <= MSG_CAP) begin
                    $display("%0t: status word expected none actual %0h", $time, out_word);
                end
            end else begin
                want = pending_status.pop_front();
                compare_field("result_code", 16'(want.result_code), 16'(out_word.result_code));
                compare_field("issued_cid", want.issued_cid, out_word.issued_cid);
                compare_field("head_now", want.head_now, out_word.head_now);
                compare_field("tail_now", want.tail_now, out_word.tail_now);
                compare_field("flow_control_on", 16'(want.flow_control_on),
                              16'(out_word.flow_control_on));
                compare_field("queue_idle", 16'(want.queue_idle), 16'(out_word.queue_idle));
                compare_field("controller_id", want.controller_id, out_word.controller_id);
            end
        end
    end

    // Receiver back-pressure comes in random bursts while it is enabled.
    initial begin
        forever begin
            @(posedge clk);
            if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sq_flow_control_tracker regression: fail");
            $finish;
        end
    end

    // Submits, responses and an unused-op word on the reset state: the default admin queue of
    // 32 slots with flow control off, before any connect has been seen.
    task automatic test_reset_state();
        send_word(pack_word(sqfc_pkg::OP_RESPONSE, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0));
        send_word(pack_word(sqfc_pkg::OP_SUBMIT, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0));
        send_word(pack_word(sqfc_pkg::OP_SUBMIT, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0));
        send_word(pack_word(sqfc_pkg::OP_RESPONSE, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0));
        send_word(pack_word(sqfc_pkg::OP_RESPONSE, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0));
        send_word(pack_word(OP_UNUSED, 1'b1, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF));
    endtask

    // One connect per failure reason in priority order, then a success whose head sits far
    // above the queue size and traffic on it, then four ways the setup registers can be wrong.
    task automatic test_connect_checks();
        send_word(pack_word(sqfc_pkg::OP_CONNECT, 1'b0, 16'd0, 1'b1, 1'b1, 16'd0, 1'b0, 16'd1));
        send_word(pack_word(sqfc_pkg::OP_CONNECT, 1'b1, 16'hFFFF, 1'b1, 1'b1, 16'd0, 1'b0,
                            16'd1));
        send_word(pack_word(sqfc_pkg::OP_CONNECT, 1'b1, 16'd0, 1'b0, 1'b1, 16'd0, 1'b0, 16'd1));
        send_word(pack_word(sqfc_pkg::OP_CONNECT, 1'b1, 16'd0, 1'b1, 1'b0, 16'd0, 1'b0, 16'd1));
        send_word(pack_word(sqfc_pkg::OP_CONNECT, 1'b1, 16'd0, 1'b1, 1'b1, sqfc_pkg::NO_FC_HEAD,
                            1'b0, 16'd1));
        send_word(pack_word(sqfc_pkg::OP_CONNECT, 1'b1, 16'd0, 1'b1, 1'b1, 16'd3, 1'b1, 16'd1));
        send_word(connect_ok(16'h7FFF, 16'hFFFF));
        send_word(pack_word(sqfc_pkg::OP_SUBMIT, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0));
        send_word(pack_word(sqfc_pkg::OP_RESPONSE, 1'b1, 16'd0, 1'b0, 1'b0, 16'd5, 1'b0, 16'd0));
        send_word(pack_word(sqfc_pkg::OP_RESPONSE, 1'b1, 16'd0, 1'b0, 1'b1, 16'd0, 1'b0, 16'd0));
        load_setup(17'd32, 1'b1, 16'd5, 1'b1, 32'd0);
        send_word(connect_ok(16'd0, 16'd2));
        load_setup(17'd32, 1'b0, 16'd7, 1'b1, 32'd1);
        send_word(connect_ok(16'd0, 16'd2));
        load_setup(17'd1, 1'b1, 16'd0, 1'b1, 32'd0);
        send_word(connect_ok(16'd0, 16'd2));
        load_setup(17'd4097, 1'b1, 16'd0, 1'b1, 32'd0);
        send_word(connect_ok(16'd0, 16'd2));
    endtask

    // The smallest queue fills after one command and its tail wraps; the largest I/O
    // queue wraps its tail through the top of the 16-bit range.
    task automatic test_queue_wrap();
        load_setup(17'd2, 1'b1, 16'd0, 1'b0, 32'd0);
        send_word(connect_ok(sqfc_pkg::NO_FC_HEAD, 16'h00A5));
        send_word(pack_word(sqfc_pkg::OP_SUBMIT, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0));
        send_word(pack_word(sqfc_pkg::OP_SUBMIT, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0));
        send_word(pack_word(sqfc_pkg::OP_RESPONSE, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0));
        send_word(pack_word(sqfc_pkg::OP_SUBMIT, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0));
        load_setup(17'd65536, 1'b0, 16'hFFFF, 1'b1, 32'd0);
        send_word(connect_ok(16'hFFFE, 16'h5A00));
        send_word(pack_word(sqfc_pkg::OP_SUBMIT, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0));
        send_word(pack_word(sqfc_pkg::OP_SUBMIT, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0));
        send_word(pack_word(sqfc_pkg::OP_RESPONSE, 1'b1, 16'd0, 1'b0, 1'b1, 16'd0, 1'b0, 16'd0));
    endtask

    // Failed transmits spend command IDs without moving the tail, so an unstalled run of
    // them keeps climbing the counter while a small queue never fills.
    task automatic test_failed_submits();
        load_setup(17'd8, 1'b0, 16'd1, 1'b0, 32'd0);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_word(connect_ok(sqfc_pkg::NO_FC_HEAD, 16'd77));
        repeat (100) begin
            send_word(pack_word(sqfc_pkg::OP_SUBMIT, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0,
                                16'd0));
        end
        send_word(pack_word(sqfc_pkg::OP_SUBMIT, 1'b1, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0));
    endtask

    // One phase of random traffic under one register setting. Idling on each side is
    // drawn afresh halfway through, so some stretches run with no idling at all.
    task automatic run_phase(input logic [16:0] entries, input logic admin,
                             input logic [15:0] qid, input logic want_fc,
                             input logic [31:0] ka, input int count, input bit calm);
        load_setup(entries, admin, qid, want_fc, ka);
        tx_idle_on = !calm && $urandom_range(0, 2) != 0;
        rx_idle_on = !calm && $urandom_range(0, 2) != 0;
        send_word(connect_ok(want_fc ? 16'd0 : sqfc_pkg::NO_FC_HEAD, 16'($urandom)));
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                tx_idle_on = !calm && $urandom_range(0, 1) != 0;
                rx_idle_on = !calm && $urandom_range(0, 1) != 0;
            end
            send_word(random_word());
        end
    endtask

    // Settings cover both roles, the size extremes, sizes the block must refuse (where
    // connects fail and the old pointers keep running), and both keep-alive extremes.
    task automatic test_random_traffic();
        run_phase(17'd2, 1'b1, 16'd0, 1'b1, 32'd0, 120, 1'b0);
        run_phase(17'd4096, 1'b1, 16'd0, 1'b0, 32'hFFFFFFFF, 120, 1'b0);
        run_phase(17'd65536, 1'b0, 16'hFFFF, 1'b1, 32'd0, 120, 1'b0);
        run_phase(17'd3, 1'b0, 16'd1, 1'b0, 32'd0, 120, 1'b0);
        run_phase(17'd0, 1'b1, 16'd0, 1'b0, 32'd0, 100, 1'b0);
        run_phase(17'd16, 1'b1, 16'd0, 1'b1, 32'($urandom), 120, 1'b0);
        run_phase(17'h1FFFF, 1'b0, 16'h8000, 1'b1, 32'd0, 100, 1'b0);
        run_phase(17'd5, 1'b1, 16'd3, 1'b1, 32'd0, 80, 1'b0);
        run_phase(17'd100, 1'b0, 16'h7FFF, 1'b0, 32'h80000000, 80, 1'b0);
        run_phase(17'd8, 1'b0, 16'd2, 1'b1, 32'd0, 140, 1'b1);
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_connect_checks();
        test_queue_wrap();
        test_failed_submits();
        test_random_traffic();
        drain_queue();
        if (err_count == 0 && pending_status.size() == 0) begin
            $display("sq_flow_control_tracker regression: pass");
        end else begin
            $display("sq_flow_control_tracker regression: fail");
        end
        $finish;
    end

endmodule
